[hw/rtl/stq_pkg.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue package
// Shared constants, codes and types of the sorted timer queue.
// ----------------------------------------------------------------------------
package stq_pkg;

  localparam int NUM_TIMERS = 16;
  localparam int IDS        = 16;
  localparam int IdW        = 4;
  localparam int TimeW      = 48;
  localparam int DelayW     = 32;
  localparam int PollW      = 16;

  localparam logic [PollW-1:0] POLL_RESET = PollW'(200);

  localparam logic [1:0] CMD_SET    = 2'd0;
  localparam logic [1:0] CMD_CANCEL = 2'd1;
  localparam logic [1:0] CMD_TICK   = 2'd2;

  localparam logic [1:0] KIND_SET    = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_INSERT,
    OP_REMOVE,
    OP_POP
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_REARM,
    ST_SCAN
  } state_e;

  typedef struct packed {
    logic             valid;
    logic [TimeW-1:0] deadline;
    logic [IdW-1:0]   timer;
  } entry_t;

  typedef struct packed {
    op_e              op;
    logic [TimeW-1:0] key;
    logic [IdW-1:0]   id;
  } chain_ctrl_t;

  typedef struct packed {
    entry_t                head;
    entry_t                second;
    logic [NUM_TIMERS-1:0] valid;
  } chain_stat_t;

endpackage

[hw/rtl/stq_cell.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue cell
// One queue entry; shifts toward the tail on insert and toward the head on
// removal, taking its new contents from a neighbor or, at the insert point, from the command.
// ----------------------------------------------------------------------------
module stq_cell
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  input  entry_t      left_i,
  input  logic        left_behind_i,
  input  logic        left_past_i,
  input  entry_t      right_i,
  output entry_t      entry_o,
  output logic        behind_o,
  output logic        past_o
);

  logic             valid_q, valid_d;
  logic [TimeW-1:0] deadline_q, deadline_d;
  logic [IdW-1:0]   timer_q, timer_d;
  logic             match;

  assign behind_o = !valid_q || (deadline_q > ctrl_i.key);
  assign match    = valid_q && (timer_q == ctrl_i.id);
  assign past_o   = left_past_i || match;

  always_comb begin
    valid_d    = valid_q;
    deadline_d = deadline_q;
    timer_d    = timer_q;
    unique case (ctrl_i.op)
      OP_INSERT: begin
        if (behind_o) begin
          if (left_behind_i) begin
            valid_d    = left_i.valid;
            deadline_d = left_i.deadline;
            timer_d    = left_i.timer;
          end else begin
            valid_d    = 1'b1;
            deadline_d = ctrl_i.key;
            timer_d    = ctrl_i.id;
          end
        end
      end
      OP_REMOVE: begin
        if (past_o) begin
          valid_d    = right_i.valid;
          deadline_d = right_i.deadline;
          timer_d    = right_i.timer;
        end
      end
      OP_POP: begin
        valid_d    = right_i.valid;
        deadline_d = right_i.deadline;
        timer_d    = right_i.timer;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    timer_q    <= timer_d;
  end

  assign entry_o = '{valid: valid_q, deadline: deadline_q, timer: timer_q};

endmodule

[hw/rtl/stq_chain.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue chain
// Row of queue cells in deadline order, cell 0 at the head.
// ----------------------------------------------------------------------------
module stq_chain
  import stq_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  chain_ctrl_t ctrl_i,
  output chain_stat_t stat_o
);

  entry_t                entries [NUM_TIMERS];
  logic [NUM_TIMERS-1:0] behind;
  logic [NUM_TIMERS-1:0] past;

  for (genvar i = 0; i < NUM_TIMERS; i++) begin : g_cell
    entry_t left_entry;
    entry_t right_entry;
    logic   left_behind;
    logic   left_past;

    if (i == 0) begin : g_head
      assign left_entry  = '0;
      assign left_behind = 1'b0;
      assign left_past   = 1'b0;
    end else begin : g_mid
      assign left_entry  = entries[i-1];
      assign left_behind = behind[i-1];
      assign left_past   = past[i-1];
    end

    if (i == NUM_TIMERS - 1) begin : g_tail
      assign right_entry = '0;
    end else begin : g_body
      assign right_entry = entries[i+1];
    end

    stq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl_i),
      .left_i        (left_entry),
      .left_behind_i (left_behind),
      .left_past_i   (left_past),
      .right_i       (right_entry),
      .entry_o       (entries[i]),
      .behind_o      (behind[i]),
      .past_o        (past[i])
    );

    assign stat_o.valid[i] = entries[i].valid;
  end

  assign stat_o.head   = entries[0];
  assign stat_o.second = entries[1];

endmodule

[hw/rtl/sorted_timer_queue.sv]
// ----------------------------------------------------------------------------
// Sorted timer queue
// One-shot timers held in deadline order in a chain of cells, with a
// millisecond clock and periodic expiry scans of the queue head.
// ----------------------------------------------------------------------------
//  Channel   Handshake                 Payload
//  command   start, busy               cmd_i, timer_id_i, delay_ms_i,
//                                      ignore_if_pending_i
//  result    result_valid_o            kind_o, result_id_o, status_o, last_o
//  config    cfg_we_i                  cfg_wdata_i (poll interval)
//
// Set and cancel are handled in the idle state; a set that re-arms a pending
// timer removes the old entry, then inserts the new one in ST_REARM. A tick
// advances the clock and, at the poll interval, starts a scan that pops due
// timers from the head. Each cycle moves the whole cell chain by at most one
// place. After reset the queue is empty, the clock is zero and the interval
// is 200. Results cannot be held off; each is shown for one cycle.
// ----------------------------------------------------------------------------
module sorted_timer_queue
  import stq_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        cmd_i,
  input  logic [IdW-1:0]    timer_id_i,
  input  logic [DelayW-1:0] delay_ms_i,
  input  logic              ignore_if_pending_i,
  output logic              result_valid_o,
  output logic [1:0]        kind_o,
  output logic [IdW-1:0]    result_id_o,
  output logic              status_o,
  output logic              last_o,
  input  logic              cfg_we_i,
  input  logic [PollW-1:0]  cfg_wdata_i
);

  state_e           state_q, state_d;
  logic [TimeW-1:0] clock_q, clock_d;
  logic [PollW-1:0] count_q, count_d;
  logic [PollW-1:0] poll_q;
  logic [IDS-1:0]   pending_q, pending_d;
  logic [TimeW-1:0] key_q, key_d;
  logic [IdW-1:0]   id_q, id_d;

  logic             rv_q, rv_d;
  logic [1:0]       kind_q, kind_d;
  logic [IdW-1:0]   rid_q, rid_d;
  logic             st_q, st_d;
  logic             last_q, last_d;

  chain_ctrl_t      ctrl;
  chain_stat_t      stat;
  logic             accept;
  logic [TimeW-1:0] new_deadline;
  logic             id_bad;
  logic [PollW-1:0] count_inc;
  logic             head_due;
  logic             second_due;

  assign busy         = (state_q != ST_IDLE);
  assign accept       = start && !busy;
  assign new_deadline = clock_q + TimeW'(delay_ms_i);
  assign id_bad       = int'(timer_id_i) >= NUM_TIMERS;
  assign count_inc    = (count_q != '1) ? count_q + PollW'(1) : count_q;
  assign head_due     = stat.head.valid && (stat.head.deadline <= clock_q);
  assign second_due   = stat.second.valid && (stat.second.deadline <= clock_q);

  always_comb begin
    state_d   = state_q;
    clock_d   = clock_q;
    count_d   = count_q;
    pending_d = pending_q;
    key_d     = key_q;
    id_d      = id_q;
    rv_d      = 1'b0;
    kind_d    = kind_q;
    rid_d     = rid_q;
    st_d      = st_q;
    last_d    = last_q;
    ctrl      = '{op: OP_NONE, key: new_deadline, id: timer_id_i};
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_i)
            CMD_SET: begin
              rv_d   = 1'b1;
              kind_d = KIND_SET;
              rid_d  = timer_id_i;
              last_d = 1'b1;
              st_d   = STATUS_OK;
              if (id_bad || (pending_q[timer_id_i] && ignore_if_pending_i)) begin
                st_d = STATUS_ERR;
              end else if (pending_q[timer_id_i]) begin
                ctrl.op = OP_REMOVE;
                key_d   = new_deadline;
                id_d    = timer_id_i;
                state_d = ST_REARM;
              end else begin
                ctrl.op                = OP_INSERT;
                pending_d[timer_id_i] = 1'b1;
              end
            end
            CMD_CANCEL: begin
              rv_d   = 1'b1;
              kind_d = KIND_CANCEL;
              rid_d  = timer_id_i;
              last_d = 1'b1;
              if (id_bad || !pending_q[timer_id_i]) begin
                st_d = STATUS_ERR;
              end else begin
                st_d                   = STATUS_OK;
                ctrl.op                = OP_REMOVE;
                pending_d[timer_id_i] = 1'b0;
              end
            end
            CMD_TICK: begin
              clock_d = clock_q + TimeW'(1);
              if (count_inc < poll_q) begin
                count_d = count_inc;
              end else begin
                count_d = '0;
                state_d = ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_REARM: begin
        ctrl    = '{op: OP_INSERT, key: key_q, id: id_q};
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        if (head_due) begin
          ctrl.op                    = OP_POP;
          pending_d[stat.head.timer] = 1'b0;
          rv_d                       = 1'b1;
          kind_d                     = KIND_EXPIRY;
          rid_d                      = stat.head.timer;
          st_d                       = STATUS_OK;
          last_d                     = !second_due;
          if (!second_due) begin
            state_d = ST_IDLE;
          end
        end else begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  stq_chain u_chain (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .stat_o (stat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      clock_q   <= '0;
      count_q   <= '0;
      poll_q    <= POLL_RESET;
      pending_q <= '0;
      rv_q      <= 1'b0;
    end else begin
      state_q   <= state_d;
      clock_q   <= clock_d;
      count_q   <= count_d;
      pending_q <= pending_d;
      rv_q      <= rv_d;
      if (cfg_we_i) begin
        poll_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q  <= key_d;
    id_q   <= id_d;
    kind_q <= kind_d;
    rid_q  <= rid_d;
    st_q   <= st_d;
    last_q <= last_d;
  end

  assign result_valid_o = rv_q;
  assign kind_o         = kind_q;
  assign result_id_o    = rid_q;
  assign status_o       = st_q;
  assign last_o         = last_q;

  a_cmd_answered: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (cmd_i == CMD_SET || cmd_i == CMD_CANCEL) |=> result_valid_o && last_o)
    else $error("set or cancel item gave no final result");

  a_head_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.second.valid |-> stat.head.valid && stat.head.deadline <= stat.second.deadline)
    else $error("queue head out of deadline order");

  a_pending_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> $countones(pending_q) == $countones(stat.valid))
    else $error("pending timers and occupied cells disagree");

  a_expiry_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && kind_o == KIND_EXPIRY |-> $past(state_q == ST_SCAN))
    else $error("expiry reported outside a scan");

  a_scan_ends_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_SCAN && state_d == ST_IDLE && rv_d |-> last_d)
    else $error("scan ended without a last marker");

endmodule
